// File: hw/rtl/rdmc_pkg.sv
// Shared types, codes and constants of the drive mode controller.
`default_nettype none

package rdmc_pkg;

    // Port widths.
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int DIST_W      = 13;

    // Motor direction codes.
    typedef enum logic [1:0] {
        DIR_OFF  = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_LINE   = 2'd0,
        MODE_AVOID  = 2'd1,
        MODE_MANUAL = 2'd2
    } mode_t;

    // Manual motion codes.
    typedef enum logic [2:0] {
        MOT_STOP  = 3'd0,
        MOT_FWD   = 3'd1,
        MOT_BACK  = 3'd2,
        MOT_LEFT  = 3'd3,
        MOT_RIGHT = 3'd4
    } motion_t;

    // Command bytes (ASCII).
    localparam logic [7:0] CMD_MODE_LINE   = 8'h31;
    localparam logic [7:0] CMD_MODE_AVOID  = 8'h32;
    localparam logic [7:0] CMD_MODE_MANUAL = 8'h33;
    localparam logic [7:0] CMD_FWD         = 8'h46;
    localparam logic [7:0] CMD_BACK        = 8'h42;
    localparam logic [7:0] CMD_LEFT        = 8'h4C;
    localparam logic [7:0] CMD_RIGHT       = 8'h52;
    localparam logic [7:0] CMD_STOP        = 8'h53;
    localparam logic [7:0] CMD_SPEED       = 8'h56;
    localparam logic [7:0] CMD_SERVO_TGL   = 8'h58;
    localparam logic [7:0] CMD_SERVO_DN    = 8'h43;
    localparam logic [7:0] CMD_SERVO_UP    = 8'h44;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_STOP = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_OPEN  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_NEAR = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_FAR  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN       = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_STEP = 4'd7;

    // Fixed duties and servo limits.
    localparam logic [7:0] VEER_LOW_DUTY  = 8'd100;
    localparam logic [7:0] VEER_HIGH_DUTY = 8'd200;
    localparam logic [7:0] SERVO_MAX      = 8'd180;
    localparam logic [7:0] SERVO_CENTER   = 8'd90;

    // Reset values of the configuration registers.
    localparam logic [DIST_W-1:0] RST_FRONT_STOP = 13'd320;
    localparam logic [DIST_W-1:0] RST_SIDE_OPEN  = 13'd480;
    localparam logic [DIST_W-1:0] RST_RIGHT_NEAR = 13'd240;
    localparam logic [DIST_W-1:0] RST_RIGHT_FAR  = 13'd400;
    localparam logic [7:0]        RST_CRUISE     = 8'd150;
    localparam logic [7:0]        RST_FAST       = 8'd255;
    localparam logic [7:0]        RST_TURN       = 8'd200;
    localparam logic [7:0]        RST_SERVO_STEP = 8'd15;

    typedef struct packed {
        dir_t       ldir;
        dir_t       rdir;
        logic [7:0] lpwm;
        logic [7:0] rpwm;
    } drive_t;

    typedef struct packed {
        logic [DIST_W-1:0] front_stop;
        logic [DIST_W-1:0] side_open;
        logic [DIST_W-1:0] right_near;
        logic [DIST_W-1:0] right_far;
        logic [7:0]        cruise;
        logic [7:0]        fast;
        logic [7:0]        turn;
        logic [7:0]        servo_step;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        motion_t    motion;
        logic       fast_on;
        logic       servo_on;
        logic [7:0] servo_angle;
        logic [7:0] servo_pos;
        drive_t     drive;
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        cmd;
        logic [5:0]        line;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] front;
        logic [DIST_W-1:0] right;
    } item_t;

    // Builds a drive word.
    function automatic drive_t make_drive(dir_t ld, dir_t rd, logic [7:0] lp, logic [7:0] rp);
        drive_t d;
        d.ldir = ld;
        d.rdir = rd;
        d.lpwm = lp;
        d.rpwm = rp;
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rdmc_core.sv
// Next-state logic: command decode, servo stepping and drive selection.
`default_nettype none

module rdmc_core (
    input  rdmc_pkg::cfg_t   cfg,
    input  rdmc_pkg::state_t cur,
    input  rdmc_pkg::item_t  item,
    output rdmc_pkg::state_t nxt
);
    import rdmc_pkg::*;

    logic       man;
    logic [8:0] up_sum;
    logic [7:0] angle_up;
    logic [7:0] angle_dn;
    logic [7:0] manual_speed;
    drive_t     stop_drive;

    assign man        = (cur.mode == MODE_MANUAL);
    assign stop_drive = make_drive(DIR_OFF, DIR_OFF, 8'd0, 8'd0);

    // Servo step with saturation at both ends.
    assign up_sum   = {1'b0, cur.servo_angle} + {1'b0, cfg.servo_step};
    assign angle_up = (up_sum > {1'b0, SERVO_MAX}) ? SERVO_MAX : up_sum[7:0];
    assign angle_dn = (cur.servo_angle < cfg.servo_step) ? 8'd0
                                                         : cur.servo_angle - cfg.servo_step;

    assign manual_speed = cur.fast_on ? cfg.fast : cfg.cruise;

    // One item's update of the controller state.
    always_comb
    begin
        nxt = cur;
        if (!item.kind)
        begin
            unique case (item.cmd)
                CMD_MODE_LINE:
                begin
                    nxt.mode  = MODE_LINE;
                    nxt.drive = stop_drive;
                end
                CMD_MODE_AVOID:
                begin
                    nxt.mode  = MODE_AVOID;
                    nxt.drive = stop_drive;
                end
                CMD_MODE_MANUAL:
                begin
                    nxt.mode  = MODE_MANUAL;
                    nxt.drive = stop_drive;
                end
                CMD_FWD:   if (man) nxt.motion = MOT_FWD;
                CMD_BACK:  if (man) nxt.motion = MOT_BACK;
                CMD_LEFT:  if (man) nxt.motion = MOT_LEFT;
                CMD_RIGHT: if (man) nxt.motion = MOT_RIGHT;
                CMD_STOP:  if (man) nxt.motion = MOT_STOP;
                CMD_SPEED: if (man) nxt.fast_on = !cur.fast_on;
                CMD_SERVO_TGL:
                begin
                    if (man)
                    begin
                        nxt.servo_on = !cur.servo_on;
                        // Switching the servo off recenters it; the angle is kept.
                        if (cur.servo_on)
                        begin
                            nxt.servo_pos = SERVO_CENTER;
                        end
                    end
                end
                CMD_SERVO_DN:
                begin
                    if (man && cur.servo_on)
                    begin
                        nxt.servo_angle = angle_dn;
                        nxt.servo_pos   = angle_dn;
                    end
                end
                CMD_SERVO_UP:
                begin
                    if (man && cur.servo_on)
                    begin
                        nxt.servo_angle = angle_up;
                        nxt.servo_pos   = angle_up;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (cur.mode)
                MODE_LINE:
                begin
                    priority if (item.line[3:2] == 2'b00)
                        nxt.drive = make_drive(DIR_FWD, DIR_FWD, cfg.cruise, cfg.cruise);
                    else if (item.line[1:0] != 2'b11)
                        nxt.drive = make_drive(DIR_BACK, DIR_FWD, cfg.turn, cfg.turn);
                    else if (item.line[5:4] != 2'b11)
                        nxt.drive = make_drive(DIR_FWD, DIR_BACK, cfg.turn, cfg.turn);
                    else
                        nxt.drive = stop_drive;
                end
                MODE_AVOID:
                begin
                    priority if (item.front < cfg.front_stop)
                    begin
                        priority if (item.right > item.left && item.right > cfg.side_open)
                            nxt.drive = make_drive(DIR_FWD, DIR_BACK, cfg.cruise, cfg.cruise);
                        else if (item.left > cfg.side_open)
                            nxt.drive = make_drive(DIR_BACK, DIR_FWD, cfg.cruise, cfg.cruise);
                        else
                            nxt.drive = make_drive(DIR_BACK, DIR_BACK, cfg.cruise, cfg.cruise);
                    end
                    else if (item.right < cfg.right_near)
                        nxt.drive = make_drive(DIR_FWD, DIR_FWD, VEER_LOW_DUTY, VEER_HIGH_DUTY);
                    else if (item.right > cfg.right_far)
                        nxt.drive = make_drive(DIR_FWD, DIR_FWD, VEER_HIGH_DUTY, VEER_LOW_DUTY);
                    else
                        nxt.drive = make_drive(DIR_FWD, DIR_FWD, cfg.cruise, cfg.cruise);
                end
                MODE_MANUAL:
                begin
                    unique case (cur.motion)
                        MOT_FWD:   nxt.drive = make_drive(DIR_FWD, DIR_FWD,
                                                          manual_speed, manual_speed);
                        MOT_BACK:  nxt.drive = make_drive(DIR_BACK, DIR_BACK,
                                                          manual_speed, manual_speed);
                        MOT_LEFT:  nxt.drive = make_drive(DIR_BACK, DIR_FWD,
                                                          manual_speed, manual_speed);
                        MOT_RIGHT: nxt.drive = make_drive(DIR_FWD, DIR_BACK,
                                                          manual_speed, manual_speed);
                        default:   nxt.drive = stop_drive;
                    endcase
                end
                default: nxt.drive = stop_drive;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/robot_drive_mode_controller.sv
// Top level: input register, controller state, result register and config port.
// Path: an accepted beat goes from the input register through the core into the result register.
// Throughput: one beat per cycle; the input register and the result register stall only
// while the result register is full and m_tready is low.
// Reset: rst_n clears the valid flags of both registers, restores the default configuration
// and sets manual mode, stopped motors, fast speed on, servo off and centered at 90 degrees.
`default_nettype none

module robot_drive_mode_controller (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // command_byte, line_sensors, left_distance, front_distance, right_distance, zero pad
    input  wire  [rdmc_pkg::S_TDATA_W-1:0]       s_tdata,
    // kind
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // left_dir, right_dir, left_pwm, right_pwm, servo_out, mode_out, zero pad
    output logic [rdmc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [rdmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [rdmc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rdmc_pkg::*;

    logic   in_valid_reg;
    item_t  in_item_reg;
    logic   out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;
    item_t  s_item;
    logic   advance;

    // Unpack the incoming beat.
    assign s_item.kind  = s_tuser;
    assign s_item.cmd   = s_tdata[7:0];
    assign s_item.line  = s_tdata[13:8];
    assign s_item.left  = s_tdata[26:14];
    assign s_item.front = s_tdata[39:27];
    assign s_item.right = s_tdata[52:40];

    // Handshake: the result register frees up when empty or taken.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    rdmc_core u_core (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= s_item;
        end
    end

    // Controller state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg         <= 1'b0;
            state_reg.mode        <= MODE_MANUAL;
            state_reg.motion      <= MOT_STOP;
            state_reg.fast_on     <= 1'b1;
            state_reg.servo_on    <= 1'b0;
            state_reg.servo_angle <= SERVO_CENTER;
            state_reg.servo_pos   <= SERVO_CENTER;
            state_reg.drive       <= make_drive(DIR_OFF, DIR_OFF, 8'd0, 8'd0);
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= {2'b00, state_next.mode, state_next.servo_pos,
                             state_next.drive.rpwm, state_next.drive.lpwm,
                             state_next.drive.rdir, state_next.drive.ldir};
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_stop <= RST_FRONT_STOP;
            cfg_reg.side_open  <= RST_SIDE_OPEN;
            cfg_reg.right_near <= RST_RIGHT_NEAR;
            cfg_reg.right_far  <= RST_RIGHT_FAR;
            cfg_reg.cruise     <= RST_CRUISE;
            cfg_reg.fast       <= RST_FAST;
            cfg_reg.turn       <= RST_TURN;
            cfg_reg.servo_step <= RST_SERVO_STEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRONT_STOP: cfg_reg.front_stop <= cfg_data;
                CFG_SIDE_OPEN:  cfg_reg.side_open  <= cfg_data;
                CFG_RIGHT_NEAR: cfg_reg.right_near <= cfg_data;
                CFG_RIGHT_FAR:  cfg_reg.right_far  <= cfg_data;
                CFG_CRUISE:     cfg_reg.cruise     <= cfg_data[7:0];
                CFG_FAST:       cfg_reg.fast       <= cfg_data[7:0];
                CFG_TURN:       cfg_reg.turn       <= cfg_data[7:0];
                CFG_SERVO_STEP: cfg_reg.servo_step <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The servo position never leaves its mechanical range.
    assert property (@(posedge clk) disable iff (!rst_n) state_reg.servo_pos <= SERVO_MAX)
        else $error("servo position above maximum");

    // With the servo off it is held at center.
    assert property (@(posedge clk) disable iff (!rst_n)
                     !state_reg.servo_on |-> state_reg.servo_pos == SERVO_CENTER)
        else $error("servo off but not centered");

    // A pending item stays in the input register while the result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
                     in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending item lost during stall");

    // The state only changes when an item moves into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
                     !(advance && in_valid_reg) |=> $stable(state_reg))
        else $error("state changed without an item");

    // The mode and servo fields of the result register mirror the held state.
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid_reg |-> out_data_reg[29:28] == state_reg.mode
                                       && out_data_reg[27:20] == state_reg.servo_pos)
        else $error("result does not match held state");

endmodule

`default_nettype wire
